### design/drp_pkg.sv
// Shared constants, tables and types for the dead-reckoning polar update block
`timescale 1ns / 1ps

package drp_pkg;

   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int RANGE_FRAC_BITS_DEF = 8;
   localparam int ATAN_LEN            = 24;
   localparam int GUARD               = 12;

   localparam logic [29:0] INV_GAIN    = 30'd652032874;
   localparam logic [15:0] DEG_FULL    = 16'd36000;
   localparam logic [15:0] MAX_AGE_RST = 16'd30000;

   // hundredths to binary angle: b*2^32/36000 = b*119304 + (b*728 + 562)/1125
   localparam logic [31:0] BAM_MUL_HI = 32'd119304;
   localparam logic [24:0] BAM_MUL_LO = 25'd728;
   localparam logic [24:0] BAM_RND    = 25'd562;
   localparam int          BAM_DIV    = 1125;

   // knots * ms to distance: 3600000 = 128 * 28125
   localparam int DIST_DIV = 28125;
   localparam int DIST_RND = 14062;

   localparam logic [31:0] BAM_QTR  = 32'h4000_0000;
   localparam logic [31:0] BAM_HALF = 32'h8000_0000;
   localparam logic [31:0] BAM_3QTR = 32'hC000_0000;

   localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic        rej;
      logic [15:0] rng;
      logic [15:0] brg;
   } echo_type;

   function automatic logic [15:0] deg_wrap(input logic [15:0] v);
      return (v >= DEG_FULL) ? v - DEG_FULL : v;
   endfunction

endpackage

### design/drp_cdiv.sv
// Two-stage divider by a constant: reciprocal estimate then one correction
`timescale 1ns / 1ps

module drp_cdiv #(
   parameter int XW  = 27,
   parameter int QW  = 13,
   parameter int DIV = 28125,
   parameter int SH  = 27
) (
   input  logic                     clock,
   input  logic                     ce,
   input  logic [XW-1:0]            x_i,
   output logic [QW-1:0]            q_o,
   output logic [$clog2(DIV)-1:0]   r_o
);

   localparam longint unsigned RECIP = (64'd1 << SH) / DIV;
   localparam int MW  = $clog2(RECIP + 1);
   localparam int PRW = XW + MW;
   localparam int RMW = $clog2(DIV);

   logic [PRW-1:0] prod;
   logic [XW-1:0]  x_ff;
   logic [QW-1:0]  qe_ff, qe_in;
   logic [XW-1:0]  qmul, rem;
   logic [QW-1:0]  q_ff, q_in;
   logic [RMW-1:0] r_ff, r_in;

   always_comb begin
      prod  = {{MW{1'b0}}, x_i} * PRW'(RECIP);
      qe_in = QW'(prod >> SH);
      qmul  = XW'(qe_ff) * XW'(DIV);
      rem   = x_ff - qmul;
      if (rem >= XW'(DIV)) begin
         q_in = qe_ff + QW'(1);
         r_in = RMW'(rem - XW'(DIV));
      end else begin
         q_in = qe_ff;
         r_in = RMW'(rem);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         x_ff  <= x_i;
         qe_ff <= qe_in;
         q_ff  <= q_in;
         r_ff  <= r_in;
      end
   end

   assign q_o = q_ff;
   assign r_o = r_ff;

endmodule

### design/drp_rot_cell.sv
// One CORDIC rotation micro-step, registered
`timescale 1ns / 1ps

module drp_rot_cell import drp_pkg::*; #(
   parameter int IDX = 0,
   parameter int W   = 32
) (
   input  logic                clock,
   input  logic                ce,
   input  logic signed [W-1:0] xi,
   input  logic signed [W-1:0] yi,
   input  logic signed [31:0]  zi,
   output logic signed [W-1:0] xo,
   output logic signed [W-1:0] yo,
   output logic signed [31:0]  zo
);

   logic signed [W-1:0] xs, ys, x_in, y_in, x_ff, y_ff;
   logic signed [31:0]  z_in, z_ff;

   always_comb begin
      xs = xi >>> IDX;
      ys = yi >>> IDX;
      if (zi >= 0) begin
         x_in = xi - ys;
         y_in = yi + xs;
         z_in = zi - $signed(ATAN_TAB[IDX]);
      end else begin
         x_in = xi + ys;
         y_in = yi - xs;
         z_in = zi + $signed(ATAN_TAB[IDX]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign xo = x_ff;
   assign yo = y_ff;
   assign zo = z_ff;

endmodule

### design/drp_vec_cell.sv
// One CORDIC vectoring micro-step, registered, with the zero-vector flag alongside
`timescale 1ns / 1ps

module drp_vec_cell import drp_pkg::*; #(
   parameter int IDX = 0,
   parameter int W   = 32
) (
   input  logic                clock,
   input  logic                ce,
   input  logic signed [W-1:0] xi,
   input  logic signed [W-1:0] yi,
   input  logic [31:0]         acci,
   input  logic                zfi,
   output logic signed [W-1:0] xo,
   output logic signed [W-1:0] yo,
   output logic [31:0]         acco,
   output logic                zfo
);

   logic signed [W-1:0] xs, ys, x_in, y_in, x_ff, y_ff;
   logic [31:0]         acc_in, acc_ff;
   logic                zf_ff;

   always_comb begin
      xs = xi >>> IDX;
      ys = yi >>> IDX;
      if (yi > 0) begin
         x_in   = xi + ys;
         y_in   = yi - xs;
         acc_in = acci + ATAN_TAB[IDX];
      end else begin
         x_in   = xi - ys;
         y_in   = yi + xs;
         acc_in = acci - ATAN_TAB[IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
         zf_ff  <= zfi;
      end
   end

   assign xo   = x_ff;
   assign yo   = y_ff;
   assign acco = acc_ff;
   assign zfo  = zf_ff;

endmodule

### design/dead_reckoning_polar_update.sv
// Top level: range/bearing dead-reckoning update, fully pipelined CORDIC
//
// Requests come in on req_* (stream, accepted when req_tvalid and req_tready are
// high). Each request gives exactly one response on rsp_*, in order.
// csr_we writes csr_wdata into the maximum report age; write only while idle.
// Throughput: one request per cycle while req_tready is high. The pipeline is
// two chains of CORDIC cells (rotation, then vectoring), one micro-rotation
// per cell, plus the constant-divider and rounding stages.
// Rejected requests flow through the same pipeline and come out echoed with
// rsp_tuser cleared.
// Reset clears the pipeline valids and the output and skid valid flags, and
// sets the maximum age to 30000 ms.
// When the receiver stalls, the output register holds and one more result is
// caught in the skid register; only then does req_tready drop and the whole
// pipeline freeze until the skid register drains.
`timescale 1ns / 1ps

module dead_reckoning_polar_update import drp_pkg::*; #(
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
   parameter int RANGE_FRAC_BITS = RANGE_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // age_ms[15:0], ground_speed_kt[26:16], range_in[42:27], bearing_in[58:43],
   // track_angle[74:59], zero padding[79:75]
   input  logic [79:0] req_tdata,
   // track_known[0], range_known[1]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // range_out[15:0], bearing_out[31:16]
   output logic [31:0] rsp_tdata,
   // valid_res[0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int N     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int F     = RANGE_FRAC_BITS;
   localparam int DSH   = F + 5;
   localparam int DISTW = F + 18;
   localparam int MAGW  = (DISTW > 28) ? DISTW : 28;
   localparam int PW    = MAGW + 4;
   localparam int X2W   = F + 20;
   localparam int QDW   = F + 6;
   localparam int LAT   = 14 + 2 * N;

   localparam logic [MAGW+29:0] MRND = (MAGW + 30)'(1) << 29;
   localparam logic [PW+29:0]   PRND = (PW + 30)'(1) << 29;
   localparam logic [PW-1:0]    GRND = PW'(1) << (GUARD - 1);
   localparam logic [47:0]      DRND = 48'h0000_8000_0000;

   logic ce;
   logic take, pv_in;

   logic [15:0]    max_age_ff;
   logic [LAT-1:0] v_ff;
   echo_type       echo_ff [LAT];
   echo_type       echo_in;

   logic [15:0] f_age, f_rng, f_brg, f_trk;
   logic [10:0] f_gs;

   logic [15:0] age0_ff, trk0_ff;
   logic [10:0] gs0_ff;
   logic [26:0] p1_ff;
   logic [15:0] bm1_ff, tm1_ff;
   logic [24:0] xb2_ff, xt2_ff;
   logic [31:0] bh2_ff, th2_ff, bh3_ff, th3_ff, bh4_ff, th4_ff;
   logic [12:0] qa3, qa4_ff, qa5_ff, qa6_ff;
   logic [14:0] ra3;
   logic [14:0] qb4, qt4;
   logic [10:0] rb4, rt4;
   logic [X2W-1:0] x2_4_ff;
   logic [QDW-1:0] qd6;
   logic [14:0]    rd6;
   logic [31:0] ab5_ff, at5_ff, ab6_ff, at6_ff, ab7_ff, at7_ff;
   logic [DISTW-1:0] dist7_ff;

   logic [MAGW-1:0] mag7 [2];
   logic [31:0]     ang7 [2];

   logic signed [PW-1:0] rx [2][N+1];
   logic signed [PW-1:0] ry [2][N+1];
   logic signed [31:0]   rz [2][N+1];

   logic signed [PW-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic                 zero_in, zero_ff;

   logic signed [PW-1:0] vx [N+1];
   logic signed [PW-1:0] vy [N+1];
   logic [31:0]          vacc [N+1];
   logic                 vzf [N+1];
   logic signed [PW-1:0] vx0_ff, vy0_ff;
   logic [31:0]          vacc0_ff;
   logic                 vzf0_ff;

   logic [PW-1:0]   xcl;
   logic [31:0]     accz;
   logic [PW+29:0]  pm_in, pm_ff;
   logic [47:0]     dg_in, dg_ff;
   logic [PW-1:0]   mfin, rfull;
   logic [47:0]     dgs;
   logic [15:0]     rr_in, rr_ff, rd_in, rd_ff;

   logic [31:0] pipe_data;
   logic        pipe_user;
   logic        out_v_ff, skid_v_ff;
   logic [31:0] out_data_ff, skid_data_ff;
   logic        out_user_ff, skid_user_ff;

   assign f_age = req_tdata[15:0];
   assign f_gs  = req_tdata[26:16];
   assign f_rng = req_tdata[42:27];
   assign f_brg = req_tdata[58:43];
   assign f_trk = req_tdata[74:59];

   assign ce         = !skid_v_ff;
   assign req_tready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= MAX_AGE_RST;
      end else if (csr_we) begin
         max_age_ff <= csr_wdata;
      end
   end

   always_comb begin
      echo_in.rej = !req_tuser[0] || (f_gs == 11'd0) || !req_tuser[1] ||
                    (f_age == 16'd0) || (f_age > max_age_ff);
      echo_in.rng = f_rng;
      echo_in.brg = f_brg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ce) begin
         v_ff <= {v_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         echo_ff[0] <= echo_in;
         for (int i = 1; i < LAT; i++) begin
            echo_ff[i] <= echo_ff[i-1];
         end
      end
   end

   // distance flown and both angles into binary form
   always_ff @(posedge clock) begin
      if (ce) begin
         age0_ff  <= f_age;
         gs0_ff   <= f_gs;
         trk0_ff  <= f_trk;
         p1_ff    <= {16'd0, gs0_ff} * {11'd0, age0_ff};
         bm1_ff   <= deg_wrap(echo_ff[0].brg);
         tm1_ff   <= deg_wrap(trk0_ff);
         xb2_ff   <= ({9'd0, bm1_ff} * BAM_MUL_LO) + BAM_RND;
         xt2_ff   <= ({9'd0, tm1_ff} * BAM_MUL_LO) + BAM_RND;
         bh2_ff   <= {16'd0, bm1_ff} * BAM_MUL_HI;
         th2_ff   <= {16'd0, tm1_ff} * BAM_MUL_HI;
         bh3_ff   <= bh2_ff;
         th3_ff   <= th2_ff;
         bh4_ff   <= bh3_ff;
         th4_ff   <= th3_ff;
         qa4_ff   <= qa3;
         x2_4_ff  <= (X2W'(ra3) << DSH) + X2W'(DIST_RND);
         ab5_ff   <= bh4_ff + 32'(qb4);
         at5_ff   <= th4_ff + 32'(qt4);
         qa5_ff   <= qa4_ff;
         ab6_ff   <= ab5_ff;
         at6_ff   <= at5_ff;
         qa6_ff   <= qa5_ff;
         ab7_ff   <= ab6_ff;
         at7_ff   <= at6_ff;
         dist7_ff <= (DISTW'(qa6_ff) << DSH) + DISTW'(qd6);
      end
   end

   drp_cdiv #(.XW(27), .QW(13), .DIV(DIST_DIV), .SH(27)) u_div_dist_hi (
      .clock (clock), .ce (ce), .x_i (p1_ff), .q_o (qa3), .r_o (ra3)
   );

   drp_cdiv #(.XW(X2W), .QW(QDW), .DIV(DIST_DIV), .SH(X2W)) u_div_dist_lo (
      .clock (clock), .ce (ce), .x_i (x2_4_ff), .q_o (qd6), .r_o (rd6)
   );

   drp_cdiv #(.XW(25), .QW(15), .DIV(BAM_DIV), .SH(25)) u_div_brg (
      .clock (clock), .ce (ce), .x_i (xb2_ff), .q_o (qb4), .r_o (rb4)
   );

   drp_cdiv #(.XW(25), .QW(15), .DIV(BAM_DIV), .SH(25)) u_div_trk (
      .clock (clock), .ce (ce), .x_i (xt2_ff), .q_o (qt4), .r_o (rt4)
   );

   assign mag7[0] = MAGW'({echo_ff[7].rng, {GUARD{1'b0}}});
   assign mag7[1] = MAGW'(dist7_ff);
   assign ang7[0] = ab7_ff;
   assign ang7[1] = at7_ff;

   // position (0) and track displacement (1) onto the north/east plane
   for (genvar v = 0; v < 2; v++) begin : g_rot
      logic [MAGW+29:0]     prod8_ff, psum;
      logic                 flip8_ff, flip_in;
      logic signed [31:0]   z8_ff, z9_ff;
      logic [MAGW-1:0]      m9;
      logic signed [PW-1:0] mx, x9_ff;

      always_comb begin
         flip_in = (ang7[v] > BAM_QTR) && (ang7[v] < BAM_3QTR);
         psum    = prod8_ff + MRND;
         m9      = MAGW'(psum >> 30);
         mx      = $signed({{(PW - MAGW){1'b0}}, m9});
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            prod8_ff <= {30'd0, mag7[v]} * {{MAGW{1'b0}}, INV_GAIN};
            flip8_ff <= flip_in;
            z8_ff    <= $signed(flip_in ? ang7[v] - BAM_HALF : ang7[v]);
            x9_ff    <= flip8_ff ? -mx : mx;
            z9_ff    <= z8_ff;
         end
      end

      assign rx[v][0] = x9_ff;
      assign ry[v][0] = '0;
      assign rz[v][0] = z9_ff;

      for (genvar i = 0; i < N; i++) begin : g_cell
         drp_rot_cell #(.IDX(i), .W(PW)) u_cell (
            .clock (clock), .ce (ce),
            .xi (rx[v][i]), .yi (ry[v][i]), .zi (rz[v][i]),
            .xo (rx[v][i+1]), .yo (ry[v][i+1]), .zo (rz[v][i+1])
         );
      end
   end

   always_comb begin
      sx_in   = rx[0][N] + rx[1][N];
      sy_in   = ry[0][N] + ry[1][N];
      zero_in = (sx_in == '0) && (sy_in == '0);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         zero_ff  <= zero_in;
         vx0_ff   <= sx_ff[PW-1] ? -sx_ff : sx_ff;
         vy0_ff   <= sx_ff[PW-1] ? -sy_ff : sy_ff;
         vacc0_ff <= sx_ff[PW-1] ? BAM_HALF : 32'd0;
         vzf0_ff  <= zero_ff;
      end
   end

   assign vx[0]   = vx0_ff;
   assign vy[0]   = vy0_ff;
   assign vacc[0] = vacc0_ff;
   assign vzf[0]  = vzf0_ff;

   for (genvar i = 0; i < N; i++) begin : g_vcell
      drp_vec_cell #(.IDX(i), .W(PW)) u_cell (
         .clock (clock), .ce (ce),
         .xi (vx[i]), .yi (vy[i]), .acci (vacc[i]), .zfi (vzf[i]),
         .xo (vx[i+1]), .yo (vy[i+1]), .acco (vacc[i+1]), .zfo (vzf[i+1])
      );
   end

   // gain removal, rounding and saturation of the range; bearing into hundredths
   always_comb begin
      xcl   = vx[N][PW-1] ? '0 : PW'(vx[N]);
      accz  = vzf[N] ? 32'd0 : vacc[N];
      pm_in = {30'd0, xcl} * {{PW{1'b0}}, INV_GAIN};
      dg_in = {16'd0, accz} * {32'd0, DEG_FULL};
      mfin  = PW'((pm_ff + PRND) >> 30);
      rfull = (mfin + GRND) >> GUARD;
      rr_in = (rfull > PW'(16'hFFFF)) ? 16'hFFFF : 16'(rfull);
      dgs   = (dg_ff + DRND) >> 32;
      rd_in = (16'(dgs) >= DEG_FULL) ? 16'd0 : 16'(dgs);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pm_ff <= pm_in;
         dg_ff <= dg_in;
         rr_ff <= rr_in;
         rd_ff <= rd_in;
      end
   end

   always_comb begin
      pipe_user = !echo_ff[LAT-1].rej;
      if (echo_ff[LAT-1].rej) begin
         pipe_data = {echo_ff[LAT-1].brg, echo_ff[LAT-1].rng};
      end else begin
         pipe_data = {rd_ff, rr_ff};
      end
   end

   assign take  = !out_v_ff || rsp_tready;
   assign pv_in = ce && v_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= pv_in;
         end
      end else if (pv_in) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= skid_v_ff ? skid_data_ff : pipe_data;
         out_user_ff <= skid_v_ff ? skid_user_ff : pipe_user;
      end else if (pv_in) begin
         skid_data_ff <= pipe_data;
         skid_user_ff <= pipe_user;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register holds a result while output register is empty");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready && !skid_v_ff && v_ff[LAT-1]) |=> skid_v_ff)
      else $error("result leaving the pipeline under stall was not caught");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_tready && skid_v_ff) |=> (out_v_ff && !skid_v_ff))
      else $error("skid register did not drain into the output register");

   a_bearing_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[31:16] < DEG_FULL))
      else $error("extrapolated bearing out of range");

endmodule

### sim/testbench.sv
// Testbench for the dead-reckoning polar update block: stream driver, monitor, predictor
`timescale 1ns / 1ps

module testbench import drp_pkg::*;;

   localparam int NSTG      = (CORDIC_STAGES_DEF < ATAN_LEN) ? CORDIC_STAGES_DEF : ATAN_LEN;
   localparam int LATENCY   = 14 + 2 * NSTG;
   localparam int CYCLE_MAX = 300000;

   typedef struct {
      logic [15:0] age;
      logic [10:0] gs;
      logic [15:0] rng;
      logic [15:0] brg;
      logic [15:0] trk;
      logic        trk_ok;
      logic        rng_ok;
   } report_type;

   typedef struct {
      logic        ok;
      logic [15:0] rng;
      logic [15:0] brg;
   } fix_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = '0;

   report_type  pending_q[$];
   fix_type     fix_q[$];
   logic [15:0] age_limit = MAX_AGE_RST;
   int          snd_idle = 0, rcv_idle = 0;
   bit          stall_go = 0;
   int          stall_left = 0;
   int          n_fail = 0, n_sent = 0, n_fix = 0, n_echo = 0;
   int          cycles = 0;

   dead_reckoning_polar_update u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] hund_to_bam(input logic [15:0] h);
      longint unsigned b;
      b = h % 36000;
      return 32'(((b << 32) + 18000) / 36000);
   endfunction

   function automatic void rotate_vec(input longint unsigned mag, input logic [31:0] a,
                                      output longint nx, output longint ey);
      longint x, y, z, xs, ys;
      x = longint'((mag * INV_GAIN + (64'd1 << 29)) >> 30);
      y = 0;
      if (a > BAM_QTR && a < BAM_3QTR) begin
         x = -x;
         a = a - BAM_HALF;
      end
      z = longint'({32'b0, a});
      if (a >= BAM_HALF) z = z - 64'sh1_0000_0000;
      for (int i = 0; i < NSTG; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'({32'b0, ATAN_TAB[i]});
         end else begin
            x += ys; y -= xs; z += longint'({32'b0, ATAN_TAB[i]});
         end
      end
      nx = x;
      ey = y;
   endfunction

   function automatic fix_type extrapolate_report(input report_type r, input logic [15:0] lim);
      fix_type f;
      longint pn, pe, tn, te, x, y, xs, ys;
      longint unsigned flown, m, rr, dg;
      logic [31:0] acc;
      if (!r.trk_ok || r.gs == 0 || !r.rng_ok || r.age == 0 || r.age > lim) begin
         f.ok = 0; f.rng = r.rng; f.brg = r.brg;
         return f;
      end
      flown = ((64'(r.gs) * 64'(r.age) << (RANGE_FRAC_BITS_DEF + GUARD)) + 1800000) / 3600000;
      rotate_vec(64'(r.rng) << GUARD, hund_to_bam(r.brg), pn, pe);
      rotate_vec(flown, hund_to_bam(r.trk), tn, te);
      x = pn + tn;
      y = pe + te;
      acc = 0;
      if (x < 0) begin
         x = -x; y = -y; acc = BAM_HALF;
      end
      for (int i = 0; i < NSTG; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; acc += ATAN_TAB[i];
         end else begin
            x -= ys; y += xs; acc -= ATAN_TAB[i];
         end
      end
      if (x < 0) x = 0;
      m  = (longint'(x) * INV_GAIN + (64'd1 << 29)) >> 30;
      rr = (m + (64'd1 << (GUARD - 1))) >> GUARD;
      if (rr > 65535) rr = 65535;
      if (pn + tn == 0 && pe + te == 0) acc = 0;
      dg = (64'(acc) * 36000 + 64'h8000_0000) >> 32;
      if (dg >= 36000) dg = 0;
      f.ok = 1; f.rng = 16'(rr); f.brg = 16'(dg);
      return f;
   endfunction

   function automatic report_type mk(input int age, gs, rng, brg, trk, tk, rk);
      report_type r;
      r.age = 16'(age); r.gs = 11'(gs); r.rng = 16'(rng); r.brg = 16'(brg);
      r.trk = 16'(trk);
      r.trk_ok = 1'(tk); r.rng_ok = 1'(rk);
      return r;
   endfunction

   // mostly extrapolable reports, some rejects and out-of-range angles
   function automatic report_type random_report(input logic [15:0] lim);
      report_type r;
      int k;
      r.age = 16'($urandom_range(lim, 1));
      r.gs  = 11'($urandom_range(2047, 1));
      r.rng = 16'($urandom());
      if ($urandom_range(3) == 0) r.rng = 16'($urandom_range(1023));
      r.brg = 16'($urandom_range(35999));
      r.trk = 16'($urandom_range(35999));
      r.trk_ok = 1;
      r.rng_ok = 1;
      k = $urandom_range(99);
      if (k < 4) r.trk_ok = 0;
      else if (k < 8) r.rng_ok = 0;
      else if (k < 11) r.gs = 0;
      else if (k < 14) r.age = 0;
      else if (k < 18) r.age = 16'($urandom());
      else if (k < 24) begin
         r.brg = 16'($urandom());
         r.trk = 16'($urandom());
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      report_type cur;
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            fix_q.push_back(extrapolate_report(cur, age_limit));
            n_sent++;
         end
         if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
            cur = pending_q.pop_front();
            req_tvalid <= 1;
            req_tdata  <= {5'b0, cur.trk, cur.brg, cur.rng, cur.gs, cur.age};
            req_tuser  <= {cur.rng_ok, cur.trk_ok};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fix_type e;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fix_q.size() == 0) begin
               $error("response with nothing expected");
               n_fail++;
            end else begin
               e = fix_q.pop_front();
               if (rsp_tuser[0] !== e.ok) begin
                  $error("valid_res: expected %0d, got %0d", e.ok, rsp_tuser[0]);
                  n_fail++;
               end
               if (rsp_tdata[15:0] !== e.rng) begin
                  $error("range_out: expected %0d, got %0d", e.rng, rsp_tdata[15:0]);
                  n_fail++;
               end
               if (rsp_tdata[31:16] !== e.brg) begin
                  $error("bearing_out: expected %0d, got %0d", e.brg, rsp_tdata[31:16]);
                  n_fail++;
               end
               if (e.ok) n_fix++; else n_echo++;
            end
         end
         if (stall_go) begin
            stall_go = 0;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_MAX) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic drain();
      while (pending_q.size() > 0 || req_tvalid || fix_q.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_limit(input logic [15:0] v);
      @(posedge clock);
      csr_we    <= 1;
      csr_wdata <= v;
      age_limit = v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic push_random(input int n);
      repeat (n) pending_q.push_back(random_report(age_limit));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      snd_idle = 10;
      rcv_idle = 48;
      // directed: extremes, rejects, wrap and zero vector
      pending_q.push_back(mk(1, 1, 0, 0, 0, 1, 1));
      pending_q.push_back(mk(30000, 2047, 65535, 35999, 35999, 1, 1));
      pending_q.push_back(mk(30001, 100, 1000, 100, 100, 1, 1));
      pending_q.push_back(mk(65535, 2047, 65535, 65535, 65535, 1, 1));
      pending_q.push_back(mk(0, 100, 500, 9000, 9000, 1, 1));
      pending_q.push_back(mk(1000, 0, 500, 9000, 9000, 1, 1));
      pending_q.push_back(mk(1000, 100, 500, 9000, 9000, 0, 1));
      pending_q.push_back(mk(1000, 100, 500, 9000, 9000, 1, 0));
      pending_q.push_back(mk(1000, 100, 500, 36000, 65535, 1, 1));
      pending_q.push_back(mk(10000, 360, 256, 0, 18000, 1, 1));
      pending_q.push_back(mk(10000, 360, 256, 9000, 27000, 1, 1));
      pending_q.push_back(mk(1, 1, 25600, 35999, 27000, 1, 1));
      pending_q.push_back(mk(1, 1, 25600, 35999, 0, 1, 1));
      pending_q.push_back(mk(30000, 2047, 65535, 0, 0, 1, 1));
      pending_q.push_back(mk(30000, 2047, 0, 0, 18000, 1, 1));
      pending_q.push_back(mk(5000, 500, 3000, 27000, 9000, 1, 1));
      pending_q.push_back(mk(5000, 500, 3000, 18000, 18000, 1, 1));
      pending_q.push_back(mk(5000, 500, 65535, 4500, 22500, 1, 1));
      pending_q.push_back(mk(65535, 0, 65535, 65535, 65535, 0, 0));
      push_random(300);
      drain();

      set_limit(16'hFFFF);
      snd_idle = 48;
      rcv_idle = 10;
      pending_q.push_back(mk(65535, 2047, 65535, 35999, 17999, 1, 1));
      push_random(200);
      stall_go = 1;
      push_random(300);
      drain();

      set_limit(16'd1);
      snd_idle = 0;
      rcv_idle = 0;
      push_random(100);
      drain();

      set_limit(16'd12000);
      push_random(350);
      while (pending_q.size() > 0 || req_tvalid || fix_q.size() > 0) @(posedge clock);
      push_random(400);
      drain();

      $display("Sent %0d requests: %0d extrapolated, %0d echoed.", n_sent, n_fix, n_echo);
      $display("Age limits 30000, 65535, 1 and 12000; idle and stall patterns on both sides.");
      if (n_fail == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
